### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, ignored while rst is high.
`define ERML_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ERML_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/erml_pkg.sv
package erml_pkg;

  localparam int DIST_W    = 16;
  localparam int ECHO_W    = 15;
  localparam int PCT_W     = 10;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 2;

  // Percent divider: widest dividend is level * 1000 (26 bits), divisor 16 bits.
  localparam int DIV_W     = 26;
  localparam int DIVISOR_W = 16;

  localparam int WINDOW_SIZE_DEF = 5;

  localparam logic [REG_IDX_W-1:0] REG_TANK_HEIGHT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_MARGIN = 2'd1;

  localparam logic [CFG_W-1:0] TANK_HEIGHT_RST    = 16'd2500;
  localparam logic [CFG_W-1:0] TIMEOUT_MARGIN_RST = 16'd500;

  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ECHO      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd2;

  // Speed of sound 343 m/s, round trip halved: dist = us * 343 / 200.
  localparam logic [8:0]  SOUND_NUM = 9'd343;
  localparam logic [7:0]  SOUND_DEN = 8'd200;
  localparam logic [9:0]  PCT_SCALE = 10'd1000;

  // Division by the sound constants is a multiply by a rounded-up reciprocal
  // and a shift. The rounding error times the largest operand stays below one
  // unit of the shift, so the quotient is exact over the full operand range.
  localparam int          DIST_PROD_W = 39;
  localparam int          DIST_SHIFT  = 23;
  localparam logic [23:0] DIST_RECIP  = 24'd14386463;  // ceil(343 * 2^23 / 200)
  localparam int          TOUT_PROD_W = 43;
  localparam int          TOUT_SHIFT  = 26;
  localparam logic [25:0] TOUT_RECIP  = 26'd39130533;  // ceil(200 * 2^26 / 343)

  localparam logic [DIV_W-1:0] DIST_MIN    = 26'd200;
  localparam logic [DIV_W-1:0] DIST_MAX    = 26'd50000;
  localparam logic [DIV_W-1:0] TIMEOUT_MIN = 26'd3000;
  localparam logic [DIV_W-1:0] TIMEOUT_MAX = 26'd30000;

  typedef struct packed {
    logic shift;  // push a new sample into the chain
    logic load;   // copy each sample into the circulating register
    logic step;   // rotate the circulating ring one place and count
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIST,
    S_LOAD,
    S_COUNT,
    S_PICK,
    S_LEVEL,
    S_PCT_START,
    S_PCT,
    S_TOUT,
    S_TWAIT,
    S_OUT
  } state_t;

endpackage

### rtl/erml_cell.sv
module erml_cell #(
  parameter int CNT_W = 3,
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  erml_pkg::cell_ctrl_t        ctrl,
  input  logic [erml_pkg::DIST_W-1:0] shift_in,
  input  logic [erml_pkg::DIST_W-1:0] circ_in,
  input  logic                        circ_vld_in,
  input  logic [CNT_W-1:0]            fill,
  input  logic [CNT_W-1:0]            rank_k,
  output logic [erml_pkg::DIST_W-1:0] val,
  output logic [erml_pkg::DIST_W-1:0] circ_out,
  output logic                        circ_vld_out,
  output logic [erml_pkg::DIST_W-1:0] pick
);

  logic [CNT_W-1:0] less_cnt;
  logic [CNT_W-1:0] le_cnt;
  logic             vld;
  logic             match;

  assign vld = CNT_W'(INDEX) < fill;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= shift_in;
    end
    if (ctrl.load) begin
      circ_out     <= val;
      circ_vld_out <= vld;
      less_cnt     <= '0;
      le_cnt       <= '0;
    end else if (ctrl.step) begin
      circ_out     <= circ_in;
      circ_vld_out <= circ_vld_in;
      if (circ_vld_out && (circ_out < val)) begin
        less_cnt <= less_cnt + 1'b1;
      end
      if (circ_vld_out && (circ_out <= val)) begin
        le_cnt <= le_cnt + 1'b1;
      end
    end
  end

  // A sample whose value spans the wanted sorted position is the median;
  // all cells that match hold the same value, so the picks can be ORed.
  assign match = vld && (less_cnt <= rank_k) && (rank_k < le_cnt);
  assign pick  = match ? val : '0;

endmodule

### rtl/erml_div.sv
module erml_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [erml_pkg::DIV_W-1:0]     dividend,
  input  logic [erml_pkg::DIVISOR_W-1:0] divisor,
  output logic                           done,
  output logic [erml_pkg::DIV_W-1:0]     quotient
);

  localparam int STEP_W = $clog2(erml_pkg::DIV_W + 1);

  logic                           busy;
  logic [STEP_W-1:0]              steps;
  logic [erml_pkg::DIVISOR_W-1:0] rem;
  logic [erml_pkg::DIVISOR_W-1:0] divr;
  logic [erml_pkg::DIVISOR_W:0]   trial;
  logic [erml_pkg::DIVISOR_W:0]   diff;
  logic                           ge;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, quotient[erml_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, divr};
  assign diff  = trial - {1'b0, divr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(erml_pkg::DIV_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      divr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[erml_pkg::DIVISOR_W-1:0] : trial[erml_pkg::DIVISOR_W-1:0];
      quotient <= {quotient[erml_pkg::DIV_W-2:0], ge};
    end
  end

endmodule

### rtl/echo_ranging_median_level_core.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_stall    echo_us
// out       out        out_valid / out_stall  status, filtered_distance, level,
//                                             level_percent, echo_timeout_us
//
// One item is worked on at a time. For a valid echo, most of the time from
// one acceptance to the next goes on the 26-step bit-serial percent
// division, which is skipped with a zero tank height, as it is for an echo
// out of range or a missing echo.
// The median is found by rotating the window once around the cell ring.
// in_stall is high from acceptance until the result has been taken.
// rst is synchronous; it empties the window and restores the registers.
`include "assert_macros.svh"

module echo_ranging_median_level_core #(
  parameter int WINDOW_SIZE = erml_pkg::WINDOW_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [erml_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [erml_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [erml_pkg::ECHO_W-1:0]    echo_us,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [erml_pkg::STATUS_W-1:0]  status,
  output logic [erml_pkg::DIST_W-1:0]    filtered_distance,
  output logic [erml_pkg::DIST_W-1:0]    level,
  output logic [erml_pkg::PCT_W-1:0]     level_percent,
  output logic [erml_pkg::ECHO_W-1:0]    echo_timeout_us
);

  localparam int CNT_W    = $clog2(WINDOW_SIZE + 1);
  localparam int TOUT_Q_W = erml_pkg::TOUT_PROD_W - erml_pkg::TOUT_SHIFT;

  erml_pkg::state_t     state;
  erml_pkg::state_t     state_next;
  erml_pkg::cell_ctrl_t cell_ctrl;

  logic [erml_pkg::CFG_W-1:0]  tank_height;
  logic [erml_pkg::CFG_W-1:0]  timeout_margin;
  logic [CNT_W-1:0]            fill;
  logic [CNT_W-1:0]            step_cnt;
  logic [erml_pkg::DIST_W-1:0] median;

  logic                              accept;
  logic                              div_start;
  logic [erml_pkg::DIV_W-1:0]        div_dividend;
  logic [erml_pkg::DIVISOR_W-1:0]    div_divisor;
  logic                              div_done;
  logic [erml_pkg::DIV_W-1:0]        div_quot;
  logic                              dist_bad;
  logic [erml_pkg::CFG_W:0]          range_sum;
  logic [erml_pkg::DIST_W-1:0]       pick_or;
  logic [erml_pkg::DIST_PROD_W-1:0]  dist_prod;
  logic [erml_pkg::DIST_W-1:0]       dist_val;
  logic [erml_pkg::TOUT_PROD_W-1:0]  tout_prod;
  logic [TOUT_Q_W-1:0]               tout_quot;

  logic [erml_pkg::DIST_W-1:0] val_a  [WINDOW_SIZE];
  logic [erml_pkg::DIST_W-1:0] circ_a [WINDOW_SIZE];
  logic                        cvld_a [WINDOW_SIZE];
  logic [erml_pkg::DIST_W-1:0] pick_a [WINDOW_SIZE];

  assign accept    = in_valid && !in_stall;
  assign dist_val  = dist_prod[erml_pkg::DIST_PROD_W-1:erml_pkg::DIST_SHIFT];
  assign dist_bad  = (erml_pkg::DIV_W'(dist_val) < erml_pkg::DIST_MIN) ||
                     (erml_pkg::DIV_W'(dist_val) > erml_pkg::DIST_MAX);
  assign range_sum = {1'b0, tank_height} + {1'b0, timeout_margin};
  assign tout_quot = tout_prod[erml_pkg::TOUT_PROD_W-1:erml_pkg::TOUT_SHIFT];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tank_height    <= erml_pkg::TANK_HEIGHT_RST;
      timeout_margin <= erml_pkg::TIMEOUT_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        erml_pkg::REG_TANK_HEIGHT:    tank_height    <= cfg_data;
        erml_pkg::REG_TIMEOUT_MARGIN: timeout_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      erml_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (echo_us == '0) ? erml_pkg::S_TOUT : erml_pkg::S_DIST;
        end
      end
      erml_pkg::S_DIST: begin
        state_next = dist_bad ? erml_pkg::S_TOUT : erml_pkg::S_LOAD;
      end
      erml_pkg::S_LOAD:  state_next = erml_pkg::S_COUNT;
      erml_pkg::S_COUNT: begin
        if (step_cnt == CNT_W'(WINDOW_SIZE - 1)) begin
          state_next = erml_pkg::S_PICK;
        end
      end
      erml_pkg::S_PICK:  state_next = erml_pkg::S_LEVEL;
      erml_pkg::S_LEVEL: begin
        state_next = (tank_height == '0) ? erml_pkg::S_TOUT : erml_pkg::S_PCT_START;
      end
      erml_pkg::S_PCT_START: state_next = erml_pkg::S_PCT;
      erml_pkg::S_PCT: begin
        if (div_done) begin
          state_next = erml_pkg::S_TOUT;
        end
      end
      erml_pkg::S_TOUT:  state_next = erml_pkg::S_TWAIT;
      erml_pkg::S_TWAIT: state_next = erml_pkg::S_OUT;
      erml_pkg::S_OUT: begin
        if (!out_stall) begin
          state_next = erml_pkg::S_IDLE;
        end
      end
      default: state_next = erml_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall        = 1'b1;
    out_valid       = 1'b0;
    div_start       = 1'b0;
    div_dividend    = '0;
    div_divisor     = '0;
    cell_ctrl.shift = 1'b0;
    cell_ctrl.load  = 1'b0;
    cell_ctrl.step  = 1'b0;
    unique case (state)
      erml_pkg::S_IDLE:  in_stall = 1'b0;
      erml_pkg::S_DIST:  cell_ctrl.shift = !dist_bad;
      erml_pkg::S_LOAD:  cell_ctrl.load  = 1'b1;
      erml_pkg::S_COUNT: cell_ctrl.step  = 1'b1;
      erml_pkg::S_PCT_START: begin
        div_start    = 1'b1;
        div_dividend = erml_pkg::DIV_W'(level) * erml_pkg::DIV_W'(erml_pkg::PCT_SCALE);
        div_divisor  = tank_height;
      end
      erml_pkg::S_OUT: out_valid = 1'b1;
      erml_pkg::S_PICK, erml_pkg::S_LEVEL, erml_pkg::S_PCT, erml_pkg::S_TOUT,
      erml_pkg::S_TWAIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= erml_pkg::S_IDLE;
      fill              <= '0;
      filtered_distance <= '0;
      level             <= '0;
      level_percent     <= '0;
    end else begin
      state <= state_next;
      if (cell_ctrl.shift && (fill != CNT_W'(WINDOW_SIZE))) begin
        fill <= fill + 1'b1;
      end
      if (state == erml_pkg::S_LEVEL) begin
        filtered_distance <= median;
        level <= (median >= tank_height) ? '0 : tank_height - median;
        if (tank_height == '0) begin
          level_percent <= '0;
        end
      end
      if ((state == erml_pkg::S_PCT) && div_done) begin
        level_percent <= div_quot[erml_pkg::PCT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= (echo_us == '0) ? erml_pkg::STATUS_NO_ECHO : erml_pkg::STATUS_OK;
      dist_prod <= erml_pkg::DIST_PROD_W'(echo_us) *
                   erml_pkg::DIST_PROD_W'(erml_pkg::DIST_RECIP);
    end else if ((state == erml_pkg::S_DIST) && dist_bad) begin
      status <= erml_pkg::STATUS_OUT_OF_RANGE;
    end
    if (state == erml_pkg::S_LOAD) begin
      step_cnt <= '0;
    end else if (state == erml_pkg::S_COUNT) begin
      step_cnt <= step_cnt + 1'b1;
    end
    if (state == erml_pkg::S_PICK) begin
      median <= pick_or;
    end
    if (state == erml_pkg::S_TOUT) begin
      tout_prod <= erml_pkg::TOUT_PROD_W'(range_sum) *
                   erml_pkg::TOUT_PROD_W'(erml_pkg::TOUT_RECIP);
    end
    if (state == erml_pkg::S_TWAIT) begin
      if (erml_pkg::DIV_W'(tout_quot) < erml_pkg::TIMEOUT_MIN) begin
        echo_timeout_us <= erml_pkg::ECHO_W'(erml_pkg::TIMEOUT_MIN);
      end else if (erml_pkg::DIV_W'(tout_quot) > erml_pkg::TIMEOUT_MAX) begin
        echo_timeout_us <= erml_pkg::ECHO_W'(erml_pkg::TIMEOUT_MAX);
      end else begin
        echo_timeout_us <= tout_quot[erml_pkg::ECHO_W-1:0];
      end
    end
  end

  erml_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Window: cell 0 takes the newest sample; the circulating copies form a ring.
  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    erml_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (cell_ctrl),
      .shift_in     ((i == 0) ? dist_val : val_a[(i + WINDOW_SIZE - 1) % WINDOW_SIZE]),
      .circ_in      (circ_a[(i + WINDOW_SIZE - 1) % WINDOW_SIZE]),
      .circ_vld_in  (cvld_a[(i + WINDOW_SIZE - 1) % WINDOW_SIZE]),
      .fill         (fill),
      .rank_k       (fill >> 1),
      .val          (val_a[i]),
      .circ_out     (circ_a[i]),
      .circ_vld_out (cvld_a[i]),
      .pick         (pick_a[i])
    );
  end

  always_comb begin
    pick_or = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      pick_or = pick_or | pick_a[i];
    end
  end

  `ERML_ASSERT(a_stall_after_accept, accept |=> in_stall, "input taken while an item is in work")
  `ERML_ASSERT(a_fill_bound, fill <= CNT_W'(WINDOW_SIZE), "window fill count beyond window size")
  `ERML_ASSERT(a_div_done_expected, div_done |-> (state == erml_pkg::S_PCT), "divider finished outside its wait state")
  `ERML_ASSERT(a_percent_bound, out_valid |-> (level_percent <= erml_pkg::PCT_W'(erml_pkg::PCT_SCALE)), "level percent above full scale")

endmodule
